/* src/rdwb_pkg.sv */
`default_nettype none

package rdwb_pkg;

  localparam int CONTIGS_DEF = 4;
  localparam int WINDOWS_DEF = 4096;

  localparam int FUNC_W     = 2;
  localparam int CIGAR_W    = 32;
  localparam int FLAGS_W    = 16;
  localparam int CTG_W      = 2;
  localparam int CTG_SLOTS  = 1 << CTG_W;
  localparam int WIDX_W     = 12;
  localparam int POS_W      = 31;
  localparam int ISZ_W      = 32;
  localparam int LIMIT_W    = 31;
  localparam int WS_W       = 16;
  localparam int CLASS_W    = 2;
  localparam int CNT_W      = 32;
  localparam int CLIP_W     = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int OP_W       = 4;
  localparam int DIV_STEPS  = POS_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = LIMIT_W'(590);
  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = LIMIT_W'(372);
  localparam logic [WS_W-1:0]    WINDOW_SIZE_RST = WS_W'(100);

  localparam logic [OP_W-1:0] OP_SOFT_CLIP = 4'd4;
  localparam logic [OP_W-1:0] OP_HARD_CLIP = 4'd5;

  localparam int FLAG_PAIRED        = 0;
  localparam int FLAG_UNMAPPED      = 2;
  localparam int FLAG_MATE_UNMAPPED = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CIGAR   = 2'd0,
    FUNC_RECORD  = 2'd1,
    FUNC_READOUT = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_LIMIT  = 2'd0,
    CFG_SHORT_LIMIT = 2'd1,
    CFG_WINDOW_SIZE = 2'd2
  } cfg_reg_t;

  typedef enum logic [CLASS_W-1:0] {
    PAIR_NONE  = 2'd0,
    PAIR_LONG  = 2'd1,
    PAIR_SHORT = 2'd2
  } pair_class_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [CLIP_W-1:0] clip;
  } window_entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [CLIP_W-1:0] sat_add_clip(input logic [CLIP_W-1:0] a,
                                                     input logic [CLIP_W-1:0] b);
    logic [CLIP_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CLIP_W] ? {CLIP_W{1'b1}} : s[CLIP_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/rdwb_if.sv */
`default_nettype none

interface rdwb_item_if;
  logic                           valid;
  logic                           ready;
  logic [rdwb_pkg::FUNC_W-1:0]    func;
  logic [rdwb_pkg::CIGAR_W-1:0]   cigar_word;
  logic [rdwb_pkg::FLAGS_W-1:0]   flags;
  logic [rdwb_pkg::CTG_W-1:0]     contig_index;
  logic [rdwb_pkg::WIDX_W-1:0]    window_index;
  logic [rdwb_pkg::POS_W-1:0]     position;
  logic [rdwb_pkg::POS_W-1:0]     end_position;
  logic [rdwb_pkg::POS_W-1:0]     mate_position;
  logic signed [rdwb_pkg::ISZ_W-1:0] insert_size;

  modport source (output valid, func, cigar_word, flags, contig_index, window_index,
                  position, end_position, mate_position, insert_size, input ready);
  modport sink (input valid, func, cigar_word, flags, contig_index, window_index,
                position, end_position, mate_position, insert_size, output ready);
endinterface

interface rdwb_result_if;
  logic                          valid;
  logic                          ready;
  logic [rdwb_pkg::CLASS_W-1:0]  pair_class;
  logic [rdwb_pkg::POS_W-1:0]    pair_start;
  logic [rdwb_pkg::ISZ_W-1:0]    pair_end;
  logic [rdwb_pkg::POS_W-1:0]    inner_start;
  logic [rdwb_pkg::POS_W-1:0]    inner_end;
  logic [rdwb_pkg::CNT_W-1:0]    window_count;
  logic [rdwb_pkg::CLIP_W-1:0]   clip_sum;
  logic [rdwb_pkg::CNT_W-1:0]    total_reads;
  logic [rdwb_pkg::CNT_W-1:0]    unmapped_reads;
  logic [rdwb_pkg::CNT_W-1:0]    contig_reads;
  logic                          index_error;

  modport source (output valid, pair_class, pair_start, pair_end, inner_start, inner_end,
                  window_count, clip_sum, total_reads, unmapped_reads, contig_reads,
                  index_error, input ready);
  modport sink (input valid, pair_class, pair_start, pair_end, inner_start, inner_end,
                window_count, clip_sum, total_reads, unmapped_reads, contig_reads,
                index_error, output ready);
endinterface

interface rdwb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rdwb_pkg::CFG_IDX_W-1:0]  index;
  logic [rdwb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/rdwb_divider.sv */
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module rdwb_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rdwb_pkg::POS_W-1:0]    dividend,
  input  logic [rdwb_pkg::WS_W-1:0]     divisor,
  output logic                          done,
  output logic [rdwb_pkg::POS_W-1:0]    quotient
);

  localparam logic [rdwb_pkg::DIV_CNT_W-1:0] LAST_STEP =
    rdwb_pkg::DIV_CNT_W'(rdwb_pkg::DIV_STEPS - 1);

  logic                            busy;
  logic [rdwb_pkg::DIV_CNT_W-1:0]  step;
  logic [rdwb_pkg::WS_W-1:0]       rem;
  logic [rdwb_pkg::WS_W-1:0]       dvsr;
  logic [rdwb_pkg::WS_W:0]         trial;
  logic                            fits;

  assign trial = {rem, quotient[rdwb_pkg::POS_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
    end else if (busy) begin
      quotient <= {quotient[rdwb_pkg::POS_W-2:0], fits};
      rem      <= fits ? rdwb_pkg::WS_W'(trial - {1'b0, dvsr}) : trial[rdwb_pkg::WS_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* src/rdwb_store.sv */
`default_nettype none

// Window count and clip sum memory. After reset a clearing pass writes zero
// to every entry, one entry per cycle.
module rdwb_store #(
  parameter int DEPTH = rdwb_pkg::CONTIGS_DEF * rdwb_pkg::WINDOWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output rdwb_pkg::window_entry_t rd_data,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  rdwb_pkg::window_entry_t wr_data,
  output logic                    clearing
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  rdwb_pkg::window_entry_t mem [DEPTH];
  logic [AW-1:0]           clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/read_depth_window_binner.sv */
// Read-depth window binner.
// Items arrive on the item channel and one result per item leaves on the result
// channel; both use valid/ready and a transaction completes when both are high.
// Configuration registers (long insert limit, short insert limit, window size)
// are written on the cfg channel, which is always ready.
// A CIGAR word item, or any other item that needs no memory access, goes straight
// from acceptance to the finishing step, which registers its result. A readout item
// takes one memory read step and one finishing step. A mapped record item runs a
// 31-step radix-2 divider to compute the window index, then one memory read step and
// one read-modify-write step; when the window lies beyond the store it goes from the
// divider straight to the finishing step. The next item can be taken in the cycle
// after the result is registered.
// After reset the block runs a clearing pass over the window memory,
// CONTIGS (at most 4) times WINDOWS entries, 16384 with the defaults, while no
// item is accepted. When the receiver stalls, the finished result waits in the
// output register and one more item may be accepted and processed; that item
// then holds in its final step until the output register is free.
`default_nettype none

module read_depth_window_binner #(
  parameter int CONTIGS = rdwb_pkg::CONTIGS_DEF,
  parameter int WINDOWS = rdwb_pkg::WINDOWS_DEF
) (
  input logic           clk,
  input logic           rst,
  rdwb_item_if.sink     item,
  rdwb_result_if.source result,
  rdwb_cfg_if.sink      cfg
);

  localparam int CTG_USED = (CONTIGS < rdwb_pkg::CTG_SLOTS) ? CONTIGS : rdwb_pkg::CTG_SLOTS;
  localparam int DEPTH    = CTG_USED * WINDOWS;
  localparam int AW       = $clog2(DEPTH);

  rdwb_pkg::state_t state;
  rdwb_pkg::state_t state_next;

  logic [rdwb_pkg::LIMIT_W-1:0] long_limit;
  logic [rdwb_pkg::LIMIT_W-1:0] short_limit;
  logic [rdwb_pkg::WS_W-1:0]    window_size;

  logic [rdwb_pkg::FUNC_W-1:0]  func_r;
  logic [rdwb_pkg::CIGAR_W-1:0] word_r;
  logic [rdwb_pkg::FLAGS_W-1:0] flags_r;
  logic [rdwb_pkg::CTG_W-1:0]   contig_r;
  logic [rdwb_pkg::WIDX_W-1:0]  widx_r;
  logic [rdwb_pkg::POS_W-1:0]   pos_r;
  logic [rdwb_pkg::POS_W-1:0]   endp_r;
  logic [rdwb_pkg::POS_W-1:0]   mpos_r;
  logic [rdwb_pkg::ISZ_W-1:0]   isz_r;
  logic                         touched;

  logic [rdwb_pkg::CNT_W-1:0]   record_count;
  logic [rdwb_pkg::CNT_W-1:0]   unmapped_count;
  logic [rdwb_pkg::CLIP_W-1:0]  pending_clip;
  logic [rdwb_pkg::CNT_W-1:0]   contig_count [rdwb_pkg::CTG_SLOTS];

  logic                         item_fire;
  logic                         contig_ok_in;
  logic                         need_div;
  logic                         readout_ok;
  logic [rdwb_pkg::POS_W:0]     pos_sum;
  logic [rdwb_pkg::WS_W-1:0]    divisor;
  logic                         div_done;
  logic [rdwb_pkg::POS_W-1:0]   quotient;
  logic                         win_ok;
  logic [rdwb_pkg::POS_W-1:0]   win_sel;

  logic                         rd_en;
  logic [AW-1:0]                mem_addr;
  rdwb_pkg::window_entry_t      rd_data;
  rdwb_pkg::window_entry_t      entry_new;
  logic                         wr_en;
  logic                         clearing;

  logic                         out_free;
  logic                         fin;
  logic                         is_cigar;
  logic                         is_rec;
  logic                         is_readout;
  logic                         contig_ok;
  logic                         mapped_ok;
  logic                         isz_pos;
  logic                         pair_elig;
  logic [rdwb_pkg::CLASS_W-1:0] cls;
  logic [rdwb_pkg::OP_W-1:0]    op;
  logic [rdwb_pkg::CNT_W-1:0]   record_next;
  logic [rdwb_pkg::CNT_W-1:0]   unmapped_next;
  logic [rdwb_pkg::CNT_W-1:0]   contig_next;
  logic [rdwb_pkg::CLIP_W-1:0]  pending_next;

  // Configuration.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_limit  <= rdwb_pkg::LONG_LIMIT_RST;
      short_limit <= rdwb_pkg::SHORT_LIMIT_RST;
      window_size <= rdwb_pkg::WINDOW_SIZE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        rdwb_pkg::CFG_LONG_LIMIT:  long_limit  <= cfg.data[rdwb_pkg::LIMIT_W-1:0];
        rdwb_pkg::CFG_SHORT_LIMIT: short_limit <= cfg.data[rdwb_pkg::LIMIT_W-1:0];
        rdwb_pkg::CFG_WINDOW_SIZE: window_size <= cfg.data[rdwb_pkg::WS_W-1:0];
        default: ;
      endcase
    end
  end

  // Item acceptance.
  assign item.ready   = (state == rdwb_pkg::ST_IDLE);
  assign item_fire    = item.valid && item.ready;
  assign contig_ok_in = int'(item.contig_index) < CONTIGS;
  assign need_div     = (item.func == rdwb_pkg::FUNC_RECORD) &&
                        !item.flags[rdwb_pkg::FLAG_UNMAPPED] && contig_ok_in;
  assign readout_ok   = (item.func == rdwb_pkg::FUNC_READOUT) && contig_ok_in &&
                        (int'(item.window_index) < WINDOWS);
  assign pos_sum      = {1'b0, item.position} + {1'b0, item.end_position};
  assign divisor      = (window_size == '0) ? rdwb_pkg::WS_W'(1) : window_size;

  always_ff @(posedge clk) begin
    if (item_fire) begin
      func_r   <= item.func;
      word_r   <= item.cigar_word;
      flags_r  <= item.flags;
      contig_r <= item.contig_index;
      widx_r   <= item.window_index;
      pos_r    <= item.position;
      endp_r   <= item.end_position;
      mpos_r   <= item.mate_position;
      isz_r    <= item.insert_size;
    end
  end

  rdwb_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (item_fire && need_div),
    .dividend (pos_sum[rdwb_pkg::POS_W:1]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign win_ok  = int'(quotient) < WINDOWS;
  assign win_sel = (func_r == rdwb_pkg::FUNC_READOUT) ? rdwb_pkg::POS_W'(widx_r) : quotient;
  assign mem_addr = AW'(int'(contig_r) * WINDOWS + int'(win_sel));
  assign rd_en   = (state == rdwb_pkg::ST_READ);

  always_ff @(posedge clk) begin
    if (item_fire) begin
      touched <= 1'b0;
    end else if (rd_en) begin
      touched <= 1'b1;
    end
  end

  rdwb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (mem_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (mem_addr),
    .wr_data  (entry_new),
    .clearing (clearing)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdwb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdwb_pkg::ST_CLEAR: begin
        if (!clearing) begin
          state_next = rdwb_pkg::ST_IDLE;
        end
      end
      rdwb_pkg::ST_IDLE: begin
        if (item_fire) begin
          if (need_div) begin
            state_next = rdwb_pkg::ST_DIV;
          end else if (readout_ok) begin
            state_next = rdwb_pkg::ST_READ;
          end else begin
            state_next = rdwb_pkg::ST_FINISH;
          end
        end
      end
      rdwb_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = win_ok ? rdwb_pkg::ST_READ : rdwb_pkg::ST_FINISH;
        end
      end
      rdwb_pkg::ST_READ: begin
        state_next = rdwb_pkg::ST_FINISH;
      end
      rdwb_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = rdwb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdwb_pkg::ST_IDLE;
      end
    endcase
  end

  // Final step: counter updates, window write-back and result.
  assign out_free   = !result.valid || result.ready;
  assign fin        = (state == rdwb_pkg::ST_FINISH) && out_free;
  assign is_cigar   = (func_r == rdwb_pkg::FUNC_CIGAR);
  assign is_rec     = (func_r == rdwb_pkg::FUNC_RECORD);
  assign is_readout = (func_r == rdwb_pkg::FUNC_READOUT);
  assign contig_ok  = int'(contig_r) < CONTIGS;
  assign mapped_ok  = is_rec && !flags_r[rdwb_pkg::FLAG_UNMAPPED] && contig_ok;
  assign isz_pos    = (isz_r != '0) && !isz_r[rdwb_pkg::ISZ_W-1];
  assign pair_elig  = mapped_ok && flags_r[rdwb_pkg::FLAG_PAIRED] &&
                      !flags_r[rdwb_pkg::FLAG_MATE_UNMAPPED] && isz_pos;
  assign op         = word_r[rdwb_pkg::OP_W-1:0];

  assign entry_new = {rdwb_pkg::sat_inc(rd_data.count),
                      rdwb_pkg::sat_add_clip(rd_data.clip, pending_clip)};
  assign wr_en     = fin && mapped_ok && touched;

  always_comb begin
    if (isz_r > {1'b0, long_limit}) begin
      cls = rdwb_pkg::PAIR_LONG;
    end else if (isz_r < {1'b0, short_limit}) begin
      cls = rdwb_pkg::PAIR_SHORT;
    end else begin
      cls = rdwb_pkg::PAIR_NONE;
    end
    if (!pair_elig) begin
      cls = rdwb_pkg::PAIR_NONE;
    end
  end

  always_comb begin
    record_next   = is_rec ? rdwb_pkg::sat_inc(record_count) : record_count;
    unmapped_next = (is_rec && flags_r[rdwb_pkg::FLAG_UNMAPPED]) ?
                    rdwb_pkg::sat_inc(unmapped_count) : unmapped_count;
    contig_next   = mapped_ok ? rdwb_pkg::sat_inc(contig_count[contig_r])
                              : contig_count[contig_r];
    pending_next  = pending_clip;
    if (is_rec) begin
      pending_next = '0;
    end else if (is_cigar && (op == rdwb_pkg::OP_SOFT_CLIP || op == rdwb_pkg::OP_HARD_CLIP)) begin
      pending_next = rdwb_pkg::sat_add_clip(pending_clip,
        rdwb_pkg::CLIP_W'(word_r[rdwb_pkg::CIGAR_W-1:rdwb_pkg::OP_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count   <= '0;
      unmapped_count <= '0;
      pending_clip   <= '0;
      for (int i = 0; i < rdwb_pkg::CTG_SLOTS; i++) begin
        contig_count[i] <= '0;
      end
    end else if (fin) begin
      record_count           <= record_next;
      unmapped_count         <= unmapped_next;
      pending_clip           <= pending_next;
      contig_count[contig_r] <= contig_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fin) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result.pair_class     <= cls;
      result.pair_start     <= (cls != rdwb_pkg::PAIR_NONE) ? pos_r : '0;
      result.pair_end       <= (cls != rdwb_pkg::PAIR_NONE) ?
                               ({1'b0, pos_r} + isz_r) : '0;
      result.inner_start    <= (cls != rdwb_pkg::PAIR_NONE) ? endp_r : '0;
      result.inner_end      <= (cls != rdwb_pkg::PAIR_NONE) ? mpos_r : '0;
      result.window_count   <= !touched ? '0 : (is_rec ? entry_new.count : rd_data.count);
      result.clip_sum       <= !touched ? '0 : (is_rec ? entry_new.clip : rd_data.clip);
      result.total_reads    <= record_next;
      result.unmapped_reads <= unmapped_next;
      result.contig_reads   <= contig_ok ? contig_next : '0;
      result.index_error    <= !touched &&
                               ((is_rec && !flags_r[rdwb_pkg::FLAG_UNMAPPED]) || is_readout);
    end
  end

endmodule

`default_nettype wire

/* verif/read_depth_window_binner_checker.sv */
`default_nettype none

module read_depth_window_binner_checker
  import rdwb_pkg::*;
#(
  parameter int CONTIGS = CONTIGS_DEF,
  parameter int WINDOWS = WINDOWS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  rdwb_item_if   item,
  rdwb_result_if result,
  rdwb_cfg_if    cfg,
  output int     errors,
  output int     outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CIGAR_W-1:0] cigar_word;
    logic [FLAGS_W-1:0] flags;
    logic [CTG_W-1:0]   contig_index;
    logic [WIDX_W-1:0]  window_index;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   end_position;
    logic [POS_W-1:0]   mate_position;
    logic [ISZ_W-1:0]   insert_size;
  } read_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] pair_class;
    logic [POS_W-1:0]   pair_start;
    logic [ISZ_W-1:0]   pair_end;
    logic [POS_W-1:0]   inner_start;
    logic [POS_W-1:0]   inner_end;
    logic [CNT_W-1:0]   window_count;
    logic [CLIP_W-1:0]  clip_sum;
    logic [CNT_W-1:0]   total_reads;
    logic [CNT_W-1:0]   unmapped_reads;
    logic [CNT_W-1:0]   contig_reads;
    logic               index_error;
  } depth_result_t;

  logic [CNT_W-1:0]   depth_count [CONTIGS*WINDOWS];
  logic [CLIP_W-1:0]  depth_clip [CONTIGS*WINDOWS];
  logic [CNT_W-1:0]   contig_count [CONTIGS];
  logic [CNT_W-1:0]   reads_seen;
  logic [CNT_W-1:0]   unmapped_seen;
  logic [CLIP_W-1:0]  clip_pending;
  logic [LIMIT_W-1:0] long_limit;
  logic [LIMIT_W-1:0] short_limit;
  logic [WS_W-1:0]    win_size;

  depth_result_t expected_q[$];
  depth_result_t want;
  depth_result_t got;
  int            failures = 0;
  bit            agree;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [CLIP_W-1:0] clip_add(input logic [CLIP_W-1:0] a,
                                                 input logic [CLIP_W-1:0] b);
    logic [CLIP_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, {CLIP_W{1'b1}}}) ? {CLIP_W{1'b1}} : s[CLIP_W-1:0];
  endfunction

  function automatic depth_result_t bin_read(input read_item_t it);
    depth_result_t r;
    logic [POS_W:0]   mid;
    logic [POS_W:0]   win;
    logic [WS_W-1:0]  ws;
    logic [OP_W-1:0]  op;
    pair_class_t      cls;
    int               addr;
    r = '0;
    case (it.func)
      FUNC_CIGAR: begin
        op = it.cigar_word[OP_W-1:0];
        if (op == OP_SOFT_CLIP || op == OP_HARD_CLIP) begin
          clip_pending = clip_add(clip_pending, CLIP_W'(it.cigar_word[CIGAR_W-1:OP_W]));
        end
      end
      FUNC_RECORD: begin
        reads_seen = bump(reads_seen);
        if (it.flags[FLAG_UNMAPPED]) begin
          unmapped_seen = bump(unmapped_seen);
        end else if (it.contig_index >= CONTIGS) begin
          r.index_error = 1'b1;
        end else begin
          ws = (win_size == '0) ? WS_W'(1) : win_size;
          mid = ({1'b0, it.position} + {1'b0, it.end_position}) >> 1;
          win = mid / ws;
          cls = PAIR_NONE;
          if (it.flags[FLAG_PAIRED] && !it.flags[FLAG_MATE_UNMAPPED] &&
              !it.insert_size[ISZ_W-1] && it.insert_size != '0) begin
            if (it.insert_size > {1'b0, long_limit}) cls = PAIR_LONG;
            else if (it.insert_size < {1'b0, short_limit}) cls = PAIR_SHORT;
          end
          if (cls != PAIR_NONE) begin
            r.pair_class  = cls;
            r.pair_start  = it.position;
            r.pair_end    = ISZ_W'({1'b0, it.position} + it.insert_size);
            r.inner_start = it.end_position;
            r.inner_end   = it.mate_position;
          end
          if (win < WINDOWS) begin
            addr = it.contig_index * WINDOWS + int'(win);
            depth_count[addr] = bump(depth_count[addr]);
            depth_clip[addr] = clip_add(depth_clip[addr], clip_pending);
            r.window_count = depth_count[addr];
            r.clip_sum = depth_clip[addr];
          end else begin
            r.index_error = 1'b1;
          end
          contig_count[it.contig_index] = bump(contig_count[it.contig_index]);
        end
        clip_pending = '0;
      end
      FUNC_READOUT: begin
        if (it.contig_index < CONTIGS && it.window_index < WINDOWS) begin
          addr = it.contig_index * WINDOWS + it.window_index;
          r.window_count = depth_count[addr];
          r.clip_sum = depth_clip[addr];
        end else begin
          r.index_error = 1'b1;
        end
      end
      default: ;
    endcase
    r.total_reads = reads_seen;
    r.unmapped_reads = unmapped_seen;
    r.contig_reads = (it.contig_index < CONTIGS) ? contig_count[it.contig_index] : '0;
    return r;
  endfunction

  function automatic bit field_agrees(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v, input bit loud);
    if (exp_v === act_v) return 1'b1;
    if (loud) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, exp_v, act_v);
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONTIGS*WINDOWS; i++) begin
        depth_count[i] = '0;
        depth_clip[i] = '0;
      end
      for (int i = 0; i < CONTIGS; i++) contig_count[i] = '0;
      reads_seen = '0;
      unmapped_seen = '0;
      clip_pending = '0;
      long_limit = LONG_LIMIT_RST;
      short_limit = SHORT_LIMIT_RST;
      win_size = WINDOW_SIZE_RST;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_LONG_LIMIT:  long_limit = cfg.data[LIMIT_W-1:0];
          CFG_SHORT_LIMIT: short_limit = cfg.data[LIMIT_W-1:0];
          CFG_WINDOW_SIZE: win_size = cfg.data[WS_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got = {result.pair_class, result.pair_start, result.pair_end, result.inner_start,
               result.inner_end, result.window_count, result.clip_sum, result.total_reads,
               result.unmapped_reads, result.contig_reads, result.index_error};
        if (expected_q.size() == 0) begin
          if (failures < 10) begin
            $display("%0t: result transaction with no item outstanding", $realtime);
          end
          failures++;
        end else begin
          want = expected_q.pop_front();
          agree = field_agrees("pair_class", 64'(want.pair_class), 64'(got.pair_class),
                               failures < 10)
                & field_agrees("pair_start", 64'(want.pair_start), 64'(got.pair_start),
                               failures < 10)
                & field_agrees("pair_end", 64'(want.pair_end), 64'(got.pair_end),
                               failures < 10)
                & field_agrees("inner_start", 64'(want.inner_start), 64'(got.inner_start),
                               failures < 10)
                & field_agrees("inner_end", 64'(want.inner_end), 64'(got.inner_end),
                               failures < 10)
                & field_agrees("window_count", 64'(want.window_count), 64'(got.window_count),
                               failures < 10)
                & field_agrees("clip_sum", 64'(want.clip_sum), 64'(got.clip_sum),
                               failures < 10)
                & field_agrees("total_reads", 64'(want.total_reads), 64'(got.total_reads),
                               failures < 10)
                & field_agrees("unmapped_reads", 64'(want.unmapped_reads),
                               64'(got.unmapped_reads), failures < 10)
                & field_agrees("contig_reads", 64'(want.contig_reads), 64'(got.contig_reads),
                               failures < 10)
                & field_agrees("index_error", 64'(want.index_error), 64'(got.index_error),
                               failures < 10);
          if (!agree) failures++;
        end
      end
      if (item.valid && item.ready) begin
        want = bin_read({item.func, item.cigar_word, item.flags,
                         item.contig_index, item.window_index, item.position,
                         item.end_position, item.mate_position,
                         item.insert_size});
        expected_q.insert(expected_q.size(), want);
      end
    end
    outstanding <= expected_q.size();
    errors <= failures;
  end

endmodule

`default_nettype wire

/* verif/read_depth_window_binner_test.sv */
`default_nettype none

module read_depth_window_binner_test;

  timeunit 1ns;
  timeprecision 1ps;

  import rdwb_pkg::*;

  localparam int STALL_LIMIT = 100000;
  localparam int BLOCK_ITEMS = 113;
  localparam logic [FUNC_W-1:0]    FUNC_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [OP_W-1:0]      OP_MATCH   = 4'd0;
  localparam logic [OP_W-1:0]      OP_TOP     = 4'hF;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CIGAR_W-1:0] cigar_word;
    logic [FLAGS_W-1:0] flags;
    logic [CTG_W-1:0]   contig_index;
    logic [WIDX_W-1:0]  window_index;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   end_position;
    logic [POS_W-1:0]   mate_position;
    logic [ISZ_W-1:0]   insert_size;
  } read_item_t;

  logic clk;
  logic rst;
  int   check_errors;
  int   outstanding;
  int   send_idle;
  int   recv_idle;
  int   sent_items;
  int   quiet_cycles;

  logic [LIMIT_W-1:0] cur_long;
  logic [LIMIT_W-1:0] cur_short;
  logic [WS_W-1:0]    cur_ws;

  rdwb_item_if   item_ch();
  rdwb_result_if result_ch();
  rdwb_cfg_if    cfg_ch();

  read_depth_window_binner u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  read_depth_window_binner_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .errors      (check_errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [FLAGS_W-1:0] sam_flags(input bit paired, input bit unmapped,
                                                   input bit mate_unmapped);
    logic [FLAGS_W-1:0] f;
    f = '0;
    f[FLAG_PAIRED] = paired;
    f[FLAG_UNMAPPED] = unmapped;
    f[FLAG_MATE_UNMAPPED] = mate_unmapped;
    return f;
  endfunction

  function automatic read_item_t noise_item();
    read_item_t it;
    it.func = FUNC_W'($urandom);
    it.cigar_word = $urandom;
    it.flags = FLAGS_W'($urandom);
    it.contig_index = CTG_W'($urandom);
    it.window_index = WIDX_W'($urandom);
    it.position = POS_W'($urandom);
    it.end_position = POS_W'($urandom);
    it.mate_position = POS_W'($urandom);
    it.insert_size = $urandom;
    return it;
  endfunction

  function automatic read_item_t cigar_op(input logic [OP_W-1:0] op,
                                          input logic [CIGAR_W-OP_W-1:0] len);
    read_item_t it;
    it = noise_item();
    it.func = FUNC_CIGAR;
    it.cigar_word = {len, op};
    return it;
  endfunction

  function automatic read_item_t record(input logic [FLAGS_W-1:0] flags,
                                        input logic [CTG_W-1:0] contig,
                                        input logic [POS_W-1:0] pos,
                                        input logic [POS_W-1:0] endp,
                                        input logic [ISZ_W-1:0] isz);
    read_item_t it;
    it = noise_item();
    it.func = FUNC_RECORD;
    it.flags = flags;
    it.contig_index = contig;
    it.position = pos;
    it.end_position = endp;
    it.insert_size = isz;
    return it;
  endfunction

  function automatic read_item_t readout(input logic [CTG_W-1:0] contig,
                                         input logic [WIDX_W-1:0] widx);
    read_item_t it;
    it = noise_item();
    it.func = FUNC_READOUT;
    it.contig_index = contig;
    it.window_index = widx;
    return it;
  endfunction

  function automatic int unsigned pick_window();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 3);
    if (r < 60) return $urandom_range(4092, 4095);
    if (r < 88) return $urandom_range(0, 4095);
    return $urandom_range(4096, 4600);
  endfunction

  function automatic logic [ISZ_W-1:0] pick_insert();
    case ($urandom_range(0, 7))
      0: return ISZ_W'(cur_long) + 32'd1 + $urandom_range(0, 500);
      1: return ISZ_W'(cur_long);
      2: return ISZ_W'(cur_short);
      3: return ISZ_W'(cur_short) - 32'd1;
      4: return (cur_long > cur_short) ?
                ISZ_W'(cur_short) + $urandom_range(0, cur_long - cur_short) : ISZ_W'(cur_short);
      5: return $urandom;
      6: return -ISZ_W'($urandom_range(1, 1000));
      default: return '0;
    endcase
  endfunction

  function automatic read_item_t random_record();
    read_item_t         it;
    longint unsigned    ws;
    longint unsigned    mid;
    longint unsigned    d;
    int unsigned        u;
    logic [FLAGS_W-1:0] f;
    ws = (cur_ws == '0) ? 1 : cur_ws;
    u = $urandom_range(0, 99);
    f = FLAGS_W'($urandom);
    if (u < 8) begin
      f[FLAG_UNMAPPED] = 1'b1;
    end else if (u < 85) begin
      f = f & ~sam_flags(1'b0, 1'b1, 1'b1) | sam_flags(1'b1, 1'b0, 1'b0);
    end else begin
      f[FLAG_UNMAPPED] = 1'b0;
    end
    it = record(f, CTG_W'($urandom), '0, '0, pick_insert());
    if ($urandom_range(0, 19) == 0) begin
      it.position = POS_W'($urandom);
      it.end_position = POS_W'($urandom);
    end else begin
      mid = pick_window() * ws + $urandom_range(0, ws - 1);
      d = $urandom_range(0, (mid < 3000) ? mid : 3000);
      it.position = POS_W'(mid - d);
      it.end_position = POS_W'(mid + d + $urandom_range(0, 1));
    end
    return it;
  endfunction

  function automatic read_item_t random_cigar();
    int unsigned        c;
    int unsigned        l;
    logic [OP_W-1:0]    op;
    logic [CIGAR_W-OP_W-1:0] len;
    c = $urandom_range(0, 99);
    op = (c < 35) ? OP_SOFT_CLIP : (c < 60) ? OP_HARD_CLIP : OP_W'($urandom);
    l = $urandom_range(0, 99);
    len = (l < 10) ? '1 : (l < 30) ? (CIGAR_W-OP_W)'($urandom) : $urandom_range(0, 200);
    return cigar_op(op, len);
  endfunction

  task automatic send_item(input read_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.func <= it.func;
    item_ch.cigar_word <= it.cigar_word;
    item_ch.flags <= it.flags;
    item_ch.contig_index <= it.contig_index;
    item_ch.window_index <= it.window_index;
    item_ch.position <= it.position;
    item_ch.end_position <= it.end_position;
    item_ch.mate_position <= it.mate_position;
    item_ch.insert_size <= it.insert_size;
    do @(posedge clk); while (!item_ch.ready);
    if (it.func != FUNC_SPARE) sent_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_limits(input logic [LIMIT_W-1:0] lng, input logic [LIMIT_W-1:0] shrt,
                                input logic [WS_W-1:0] ws);
    write_reg(CFG_LONG_LIMIT, {1'($urandom), lng});
    write_reg(CFG_SHORT_LIMIT, {1'($urandom), shrt});
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_WINDOW_SIZE, {16'($urandom), ws});
    cfg_ch.valid <= 1'b0;
    cur_long = lng;
    cur_short = shrt;
    cur_ws = ws;
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_reads(input int target);
    int unsigned r;
    while (sent_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_item(noise_item());
      end else if (r < 14) begin
        send_item(readout(CTG_W'($urandom), ($urandom_range(0, 9) < 7) ?
                          WIDX_W'(pick_window()) : WIDX_W'($urandom)));
      end else begin
        repeat ($urandom_range(0, 3)) send_item(random_cigar());
        send_item(random_record());
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.func <= FUNC_CIGAR;
    item_ch.cigar_word <= '0;
    item_ch.flags <= '0;
    item_ch.contig_index <= '0;
    item_ch.window_index <= '0;
    item_ch.position <= '0;
    item_ch.end_position <= '0;
    item_ch.mate_position <= '0;
    item_ch.insert_size <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_LONG_LIMIT;
    cfg_ch.data <= '0;
    send_idle = 29;
    recv_idle = 52;
    sent_items = 0;
    cur_long = LONG_LIMIT_RST;
    cur_short = SHORT_LIMIT_RST;
    cur_ws = WINDOW_SIZE_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(readout(0, 0));
    send_item(readout(3, 4095));
    send_item(cigar_op(OP_SOFT_CLIP, '1));
    send_item(cigar_op(OP_HARD_CLIP, 7));
    send_item(cigar_op(OP_MATCH, 50));
    send_item(cigar_op(OP_TOP, 9));
    send_item(record(sam_flags(1, 0, 0), 0, 10, 150, 600));
    send_item(record(sam_flags(1, 1, 0), 1, 10, 150, 600));
    send_item(cigar_op(OP_SOFT_CLIP, 3));
    send_item(record(sam_flags(1, 0, 0), 1, 0, 0, 372));
    send_item(record(sam_flags(1, 0, 0), 2, 250, 251, 371));
    send_item(record(sam_flags(1, 0, 0), 2, 250, 251, 590));
    send_item(record(sam_flags(1, 0, 0), 2, 250, 251, 591));
    send_item(record(sam_flags(1, 0, 1), 0, 10, 150, 1000));
    send_item(record(sam_flags(1, 0, 0), 0, 10, 150, -600));
    send_item(record(sam_flags(1, 0, 0), 0, 10, 150, 0));
    send_item(record('0, 0, 10, 150, 1000));
    send_item(record(sam_flags(1, 0, 0), 1, 409600, 409600, 700));
    send_item(record(sam_flags(1, 0, 0), 1, '1, '1, 32'h7FFF_FFFF));
    send_item(record(~sam_flags(0, 1, 1), 3, 409599, 409599, 32'h7FFF_FFFF));
    send_item(readout(3, 4095));
    send_item(readout(0, 0));
    send_item(cigar_op(OP_HARD_CLIP, 5));
    send_item(record('1, 2, 0, 0, 0));
    send_item(readout(2, 2));
    begin
      read_item_t spare;
      spare = noise_item();
      spare.func = FUNC_SPARE;
      send_item(spare);
    end

    for (int blk = 0; blk < 6; blk++) begin
      drain();
      case (blk)
        0: program_limits(590, 372, 100);
        1: program_limits($urandom_range(400, 2000), $urandom_range(0, 400),
                          $urandom_range(1, 500));
        2: program_limits('1, '0, '0);
        3: program_limits('0, '1, '1);
        4: program_limits(1, 1, 1);
        default: program_limits(LIMIT_W'($urandom), LIMIT_W'($urandom),
                                $urandom_range(1, 65535));
      endcase
      if (blk == 2) begin
        send_idle = 52;
        recv_idle = 29;
      end else if (blk == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_reads(sent_items + BLOCK_ITEMS);
    end

    drain();
    repeat (40) @(posedge clk);
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
